[hw/rtl/lsps_pkg.sv]
// Shared types, codes and the pulse scan function for the solenoid pulse sequencer.
`default_nettype none
package lsps_pkg;

    localparam int MASK_W        = 8;
    localparam int WIDTH_W       = 8;
    localparam int TICKS_W       = 9;
    localparam int POS_W         = 3;
    localparam int VALVE_MAX     = 8;
    localparam int VALVE_COUNT_D = 2;

    localparam logic [WIDTH_W-1:0] WIDTH_RESET = 8'd25;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_SET   = 2'd1;
    localparam logic [1:0] OP_SLEEP = 2'd2;

    localparam logic [2:0] REG_OPEN_FIRST   = 3'd0;
    localparam logic [2:0] REG_OPEN_OTHERS  = 3'd1;
    localparam logic [2:0] REG_CLOSE_FIRST  = 3'd2;
    localparam logic [2:0] REG_CLOSE_OTHERS = 3'd3;

    typedef logic [MASK_W-1:0]  t_mask;
    typedef logic [WIDTH_W-1:0] t_width;

    typedef struct packed {
        t_width open_first;
        t_width open_others;
        t_width close_first;
        t_width close_others;
    } t_widths;

    typedef struct packed {
        logic              active;
        logic [POS_W-1:0]  pos;
        logic [TICKS_W-1:0] ticks;
        logic              polarity;
        t_mask             pend_open;
        t_mask             pend_close;
        t_mask             open_state;
    } t_scan;

    typedef struct packed {
        t_mask positive_drive;
        t_mask negative_drive;
        t_mask valve_mask;
        logic  busy_res;
        logic  rejected;
    } t_result;

    // Finds the lowest pending valve with a nonzero width. Pending valves below
    // it whose width is zero are switched at once without a pulse.
    function automatic t_scan f_start_next(input t_mask p_open, input t_mask p_close,
                                           input t_mask open_st, input t_mask target,
                                           input t_widths w);
        t_scan  s;
        logic   found;
        logic   op;
        t_width wv;
        s            = '0;
        s.open_state = open_st;
        s.pend_open  = p_open;
        s.pend_close = p_close;
        found        = 1'b0;
        for (int v = 0; v < VALVE_MAX; v++) begin
            op = p_open[v];
            if (op) begin
                wv = (v == 0) ? w.open_first : w.open_others;
            end else begin
                wv = (v == 0) ? w.close_first : w.close_others;
            end
            if (!found && (p_open[v] || p_close[v])) begin
                if (wv == '0) begin
                    s.open_state[v] = op;
                    s.pend_open[v]  = 1'b0;
                    s.pend_close[v] = 1'b0;
                end else begin
                    found      = 1'b1;
                    s.active   = 1'b1;
                    s.pos      = POS_W'(v);
                    s.ticks    = {wv, 1'b0};
                    s.polarity = op;
                end
            end
        end
        if (!found) begin
            s.pend_open  = '0;
            s.pend_close = '0;
            s.open_state = target;
        end
        return s;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/lsps_cfg.sv]
// Pulse width registers written through the configuration port.
`default_nettype none
module lsps_cfg
    import lsps_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [2:0] i_cfg_index,
    input  wire t_width     i_cfg_data,
    output t_widths         o_widths
);

    t_widths r_widths;

    assign o_cfg_ready = 1'b1;
    assign o_widths    = r_widths;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_widths.open_first   <= WIDTH_RESET;
            r_widths.open_others  <= WIDTH_RESET;
            r_widths.close_first  <= WIDTH_RESET;
            r_widths.close_others <= WIDTH_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_OPEN_FIRST:   r_widths.open_first   <= i_cfg_data;
                REG_OPEN_OTHERS:  r_widths.open_others  <= i_cfg_data;
                REG_CLOSE_FIRST:  r_widths.close_first  <= i_cfg_data;
                REG_CLOSE_OTHERS: r_widths.close_others <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

[hw/rtl/lsps_core.sv]
// Input register, sequencer state and the single-pass next-state logic.
`default_nettype none
module lsps_core
    import lsps_pkg::*;
#(
    parameter int VALVE_COUNT = VALVE_COUNT_D
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [1:0] i_operation,
    input  wire t_mask      i_desired_mask,
    input  wire t_widths    i_widths,
    input  wire logic       i_out_free,
    output logic            o_load,
    output t_result         o_result
);

    localparam t_mask VALID_MASK = MASK_W'((16'd1 << VALVE_COUNT) - 16'd1);

    logic               r_in_valid, n_in_valid;
    logic [1:0]         r_op;
    t_mask              r_want;

    t_mask              r_open_state, n_open_state;
    t_mask              r_target, n_target;
    t_mask              r_pend_open, n_pend_open;
    t_mask              r_pend_close, n_pend_close;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [TICKS_W-1:0] r_ticks, n_ticks;
    logic               r_active, n_active;
    logic               r_polarity, n_polarity;

    logic               accept;
    logic               fire;
    logic               rej;
    logic [TICKS_W-1:0] ticks_dec;
    t_mask              fin_open, fin_close, fin_state, want_m;
    t_mask              bit_sel;
    t_scan              scan;
    t_mask              scan_open, scan_close, scan_state, scan_target;

    assign o_in_stall = r_in_valid && !i_out_free;
    assign accept     = i_in_valid && !o_in_stall;
    assign fire       = r_in_valid && i_out_free;
    assign o_load     = fire;
    assign n_in_valid = accept ? 1'b1 : (fire ? 1'b0 : r_in_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
        if (accept) begin
            r_op   <= i_operation;
            r_want <= i_desired_mask;
        end
    end

    assign want_m    = r_want & VALID_MASK;
    assign ticks_dec = (r_ticks != '0) ? r_ticks - TICKS_W'(1) : r_ticks;
    assign bit_sel   = MASK_W'(1) << r_pos;

    // The pulse that just ran out is recorded before the scan picks the next one.
    always_comb begin
        fin_open  = r_pend_open & ~bit_sel;
        fin_close = r_pend_close & ~bit_sel;
        fin_state = r_polarity ? (r_open_state | bit_sel) : (r_open_state & ~bit_sel);
        if (r_op == OP_SET) begin
            scan_open   = want_m & ~r_open_state;
            scan_close  = r_open_state & ~want_m;
            scan_state  = r_open_state;
            scan_target = want_m;
        end else begin
            scan_open   = fin_open;
            scan_close  = fin_close;
            scan_state  = fin_state;
            scan_target = r_target;
        end
        scan = f_start_next(scan_open, scan_close, scan_state, scan_target, i_widths);
    end

    always_comb begin
        n_open_state = r_open_state;
        n_target     = r_target;
        n_pend_open  = r_pend_open;
        n_pend_close = r_pend_close;
        n_pos        = r_pos;
        n_ticks      = r_ticks;
        n_active     = r_active;
        n_polarity   = r_polarity;
        rej          = 1'b0;
        case (r_op)
            OP_TICK: begin
                if (r_active) begin
                    if (ticks_dec == '0) begin
                        n_open_state = scan.open_state;
                        n_pend_open  = scan.pend_open;
                        n_pend_close = scan.pend_close;
                        n_pos        = scan.pos;
                        n_ticks      = scan.ticks;
                        n_active     = scan.active;
                        n_polarity   = scan.polarity;
                    end else begin
                        n_ticks = ticks_dec;
                    end
                end
            end
            OP_SET: begin
                if (r_active) begin
                    rej = 1'b1;
                end else begin
                    n_target     = want_m;
                    n_open_state = scan.open_state;
                    n_pend_open  = scan.pend_open;
                    n_pend_close = scan.pend_close;
                    n_pos        = scan.pos;
                    n_ticks      = scan.ticks;
                    n_active     = scan.active;
                    n_polarity   = scan.polarity;
                end
            end
            OP_SLEEP: begin
                n_open_state = '0;
                n_target     = '0;
                n_pend_open  = '0;
                n_pend_close = '0;
                n_pos        = '0;
                n_ticks      = '0;
                n_active     = 1'b0;
                n_polarity   = 1'b0;
            end
            default: ;
        endcase
    end

    always_comb begin
        o_result.positive_drive = (n_active && n_polarity) ? (MASK_W'(1) << n_pos) : '0;
        o_result.negative_drive = (n_active && !n_polarity) ? (MASK_W'(1) << n_pos) : '0;
        o_result.valve_mask     = n_open_state;
        o_result.busy_res       = n_active;
        o_result.rejected       = rej;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open_state <= '0;
            r_target     <= '0;
            r_pend_open  <= '0;
            r_pend_close <= '0;
            r_pos        <= '0;
            r_ticks      <= '0;
            r_active     <= 1'b0;
            r_polarity   <= 1'b0;
        end else if (fire) begin
            r_open_state <= n_open_state;
            r_target     <= n_target;
            r_pend_open  <= n_pend_open;
            r_pend_close <= n_pend_close;
            r_pos        <= n_pos;
            r_ticks      <= n_ticks;
            r_active     <= n_active;
            r_polarity   <= n_polarity;
        end
    end

    a_active_has_ticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_ticks != '0))
        else $error("pulse active with no ticks left");

    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_active |-> (r_pend_open == '0 && r_pend_close == '0))
        else $error("pending valves left while idle");

    a_pending_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_pend_open | r_pend_close) & ~VALID_MASK) == '0 &&
        (r_pend_open & r_pend_close) == '0)
        else $error("pending masks out of range or overlapping");

    a_reject_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_op == OP_SET && r_active) |=>
        ($stable(r_target) && $stable(r_open_state) && $stable(r_pos)))
        else $error("rejected request changed the state");

endmodule
`default_nettype wire

[hw/rtl/lsps_out.sv]
// Result register that holds one result until the consumer takes it.
`default_nettype none
module lsps_out
    import lsps_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_result,
    output logic         o_free,
    output logic         o_out_valid,
    input  wire logic    i_out_stall,
    output t_result      o_result
);

    logic    r_valid, n_valid;
    t_result r_result;

    assign o_free      = !r_valid || !i_out_stall;
    assign o_out_valid = r_valid;
    assign o_result    = r_result;
    assign n_valid     = i_load ? 1'b1 : (r_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/latching_solenoid_pulse_sequencer_unit.sv]
// Top level of the latching solenoid pulse sequencer.
//
//  Channel  Direction  Handshake               Payload
//  in       input      i_in_valid / o_in_stall  i_operation, i_desired_mask
//  out      output     o_out_valid / i_out_stall drives, valve mask, busy, rejected
//  cfg      input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// A request is registered at the input, then processed into the result register;
// one request per cycle is sustained while the output is not stalled. The result
// register parts the two sides, so a held result stalls the input only when the
// input register is also full.
// Synchronous active-low reset clears the valid flags and the sequencer state; the widths return to 25.
`default_nettype none
module latching_solenoid_pulse_sequencer_unit
    import lsps_pkg::*;
#(
    parameter int VALVE_COUNT = VALVE_COUNT_D
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [1:0]        i_operation,
    input  wire logic [MASK_W-1:0] i_desired_mask,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [MASK_W-1:0]      o_positive_drive,
    output logic [MASK_W-1:0]      o_negative_drive,
    output logic [MASK_W-1:0]      o_valve_mask,
    output logic                   o_busy_res,
    output logic                   o_rejected,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [2:0]        i_cfg_index,
    input  wire logic [WIDTH_W-1:0] i_cfg_data
);

    t_widths widths;
    t_result core_result;
    t_result out_result;
    logic    load;
    logic    out_free;

    lsps_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_widths    (widths)
    );

    lsps_core #(
        .VALVE_COUNT (VALVE_COUNT)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_operation    (i_operation),
        .i_desired_mask (i_desired_mask),
        .i_widths       (widths),
        .i_out_free     (out_free),
        .o_load         (load),
        .o_result       (core_result)
    );

    lsps_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .i_result    (core_result),
        .o_free      (out_free),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (out_result)
    );

    assign o_positive_drive = out_result.positive_drive;
    assign o_negative_drive = out_result.negative_drive;
    assign o_valve_mask     = out_result.valve_mask;
    assign o_busy_res       = out_result.busy_res;
    assign o_rejected       = out_result.rejected;

endmodule
`default_nettype wire
